// ----- rtl/core/sitda_pkg.sv -----
// shared types, constants and functions for the signed integer to decimal text core
package sitda_pkg;

	localparam int BIN_W       = 32;
	localparam int BCD_DIGITS  = 10;
	localparam int BCD_W       = 4 * BCD_DIGITS;
	localparam int WORD_W      = BCD_W + BIN_W;
	localparam int STAGE_STEPS = 8;
	localparam int IDX_W       = 4;
	localparam int CHAR_W      = 8;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

	// one item in flight: sign plus the shift word {bcd digits, remaining binary bits}
	typedef struct packed {
		logic              neg;
		logic [WORD_W-1:0] word;
	} sitda_item_t;

	// one double-dabble step: add three to every digit of five or more, then shift left
	function automatic logic [WORD_W-1:0] dd_step(input logic [WORD_W-1:0] word_in);
		logic [WORD_W-1:0] w;
		w = word_in;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (w[BIN_W + 4*i +: 4] >= 4'd5) begin
				w[BIN_W + 4*i +: 4] = w[BIN_W + 4*i +: 4] + 4'd3;
			end
		end
		return {w[WORD_W-2:0], 1'b0};
	endfunction

	// position of the most significant nonzero digit, zero when all digits are zero
	function automatic logic [IDX_W-1:0] msd_index(input logic [BCD_W-1:0] bcd);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd[4*i +: 4] != 4'd0) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- rtl/core/sitda_dd_stage.sv -----
// one registered pipeline stage of eight double-dabble steps
module sitda_dd_stage
	import sitda_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_valid,
	output logic        s_ready,
	input  sitda_item_t s_item,
	output logic        m_valid,
	input  logic        m_ready,
	output sitda_item_t m_item
);

	logic        valid_s1;
	sitda_item_t item_s1;
	sitda_item_t item_next;

	// eight shift steps on the combined word
	always_comb begin
		item_next = s_item;
		for (int k = 0; k < STAGE_STEPS; k++) begin
			item_next.word = dd_step(item_next.word);
		end
	end

	assign s_ready = !valid_s1 || m_ready;

	// stage register, holds while downstream stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_ready) begin
			valid_s1 <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_ready && s_valid) begin
			item_s1 <= item_next;
		end
	end

	assign m_valid = valid_s1;
	assign m_item  = item_s1;

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii_core.sv -----
// signed 32-bit integer to decimal ascii text converter, top level
//
//  channel   dir  bus              contents
//  s_axis    in   tdata[31:0]      value (signed)
//  m_axis    out  tdata[7:0]       character, tlast = final_char
//
// an item goes through a sign/magnitude stage and four double-dabble stages (eight
// shift steps each) before the character emitter loads it and sends its characters
// as the output takes them; the emitter takes no new item until the last character
// of the current one is sent, and that sets the sustained rate. reset clears only
// valid bits and the emitter and output registers; there is no clearing pass.
// stalls on the output back up through the pipeline without loss or repetition.
module signed_int_to_decimal_ascii_core
	import sitda_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [BIN_W-1:0]  s_axis_tdata,   // [31:0] value
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [CHAR_W-1:0] m_axis_tdata,   // [7:0] character
	output logic              m_axis_tlast
);

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        ready_s1, ready_s2, ready_s3, ready_s4, ready_s5;
	sitda_item_t item_s1, item_s2, item_s3, item_s4, item_s5;

	logic              em_act_q;
	logic              em_neg_q;
	logic [IDX_W-1:0]  em_idx_q;
	logic [BCD_W-1:0]  em_bcd_q;
	logic              m_valid_q;
	logic [CHAR_W-1:0] m_data_q;
	logic              m_last_q;

	logic              out_free;
	logic              emit;
	logic              load;
	logic [CHAR_W-1:0] next_char;
	logic              next_last;

	// stage 1: sign and two's complement magnitude
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			item_s1.neg  <= s_axis_tdata[BIN_W-1];
			item_s1.word <= {{BCD_W{1'b0}},
				(s_axis_tdata[BIN_W-1] ? (~s_axis_tdata + BIN_W'(1)) : s_axis_tdata)};
		end
	end

	// stages 2 to 5: binary to bcd, 32 shift steps in all
	sitda_dd_stage u_dd_s2 (
		.clk(clk), .arst_n(arst_n),
		.s_valid(valid_s1), .s_ready(ready_s2), .s_item(item_s1),
		.m_valid(valid_s2), .m_ready(ready_s3), .m_item(item_s2)
	);
	sitda_dd_stage u_dd_s3 (
		.clk(clk), .arst_n(arst_n),
		.s_valid(valid_s2), .s_ready(ready_s3), .s_item(item_s2),
		.m_valid(valid_s3), .m_ready(ready_s4), .m_item(item_s3)
	);
	sitda_dd_stage u_dd_s4 (
		.clk(clk), .arst_n(arst_n),
		.s_valid(valid_s3), .s_ready(ready_s4), .s_item(item_s3),
		.m_valid(valid_s4), .m_ready(ready_s5), .m_item(item_s4)
	);
	sitda_dd_stage u_dd_s5 (
		.clk(clk), .arst_n(arst_n),
		.s_valid(valid_s4), .s_ready(ready_s5), .s_item(item_s4),
		.m_valid(valid_s5), .m_ready(!em_act_q), .m_item(item_s5)
	);

	// emitter control and next character
	always_comb begin
		out_free = !m_valid_q || m_axis_tready;
		emit     = out_free && em_act_q;
		load     = valid_s5 && !em_act_q;
		if (em_neg_q) begin
			next_char = ASCII_MINUS;
			next_last = 1'b0;
		end else begin
			next_char = ASCII_ZERO + {4'b0000, em_bcd_q[{em_idx_q, 2'b00} +: 4]};
			next_last = (em_idx_q == '0);
		end
	end

	// emitter: minus sign first, then digits from the most significant one down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_act_q  <= 1'b0;
			em_neg_q  <= 1'b0;
			em_idx_q  <= '0;
			em_bcd_q  <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
			m_last_q  <= 1'b0;
		end else begin
			if (load) begin
				em_act_q <= 1'b1;
				em_neg_q <= item_s5.neg;
				em_idx_q <= msd_index(item_s5.word[WORD_W-1:BIN_W]);
				em_bcd_q <= item_s5.word[WORD_W-1:BIN_W];
			end else if (emit) begin
				if (em_neg_q) begin
					em_neg_q <= 1'b0;
				end else if (em_idx_q == '0) begin
					em_act_q <= 1'b0;
				end else begin
					em_idx_q <= em_idx_q - IDX_W'(1);
				end
			end
			if (emit) begin
				m_valid_q <= 1'b1;
				m_data_q  <= next_char;
				m_last_q  <= next_last;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
	// a minus sign never closes a run
	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> !(m_last_q && (m_data_q == ASCII_MINUS)))
		else $error("minus sign flagged as last character");

	// digit index stays within the ten bcd digits
	assert property (@(posedge clk) disable iff (!arst_n)
		em_act_q |-> (em_idx_q < IDX_W'(BCD_DIGITS)))
		else $error("emitter digit index out of range");

	// an item waiting for the emitter is held unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && em_act_q) |=> (valid_s5 && $stable(item_s5)))
		else $error("last pipeline stage lost or changed a stalled item");

	// a loaded item always starts the emitter
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> em_act_q)
		else $error("emitter did not start after load");
`endif

endmodule

// ----- bench/tb_signed_int_to_decimal_ascii_core.sv -----
// testbench for signed_int_to_decimal_ascii_core: random and corner values, stalls, checked text
module tb_signed_int_to_decimal_ascii_core;
	import sitda_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_TICKS = 24;
	localparam int LONG_HOLD    = 400;

	// receiver stall patterns
	typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE} rx_pattern_e;

	// expected text for every accepted value, one character per entry
	class text_scoreboard;
		typedef struct packed {
			logic [CHAR_W-1:0] ch;
			logic              fin;
		} char_t;

		char_t expected_text[$];
		int    errors;

		function new();
			errors = 0;
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		// spell the value in decimal: sign first, then magnitude digits, most significant first
		function void note_value(logic [BIN_W-1:0] value);
			logic [BIN_W-1:0] mag;
			logic [3:0]       digit_stack[$];
			char_t            c;
			mag = value[BIN_W-1] ? (~value + 1'b1) : value;
			if (value[BIN_W-1]) begin
				c.ch  = ASCII_MINUS;
				c.fin = 1'b0;
				expected_text.push_back(c);
			end
			// zero still gives one digit
			do begin
				digit_stack.push_front(4'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
			foreach (digit_stack[i]) begin
				c.ch  = ASCII_ZERO + CHAR_W'(digit_stack[i]);
				c.fin = (i == digit_stack.size() - 1);
				expected_text.push_back(c);
			end
		endfunction

		task check_char(logic [CHAR_W-1:0] ch, logic fin);
			char_t want;
			if (expected_text.size() == 0) begin
				report_mismatch($sformatf("character %0d with nothing pending", ch));
			end else begin
				want = expected_text.pop_front();
				if (ch !== want.ch)
					report_mismatch($sformatf("character %0d, want %0d", ch, want.ch));
				if (fin !== want.fin)
					report_mismatch($sformatf("last flag %0b, want %0b", fin, want.fin));
			end
		endtask
	endclass

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [BIN_W-1:0]  s_axis_tdata  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [CHAR_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;

	text_scoreboard sb = new();
	rx_pattern_e    rx_pattern = RX_ALWAYS;
	bit             hold_pending = 1'b0;
	int             cycle_count = 0;

	signed_int_to_decimal_ascii_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** signed_int_to_decimal_ascii_core: FAILED **");
			$finish;
		end
	end

	// check every accepted character
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_char(m_axis_tdata, m_axis_tlast);
	end

	// receiver: stall pattern, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			case (rx_pattern)
				RX_ALWAYS: m_axis_tready <= 1'b1;
				RX_HALF:   m_axis_tready <= 1'($urandom_range(1, 0));
				default:   m_axis_tready <= ($urandom_range(3, 0) == 0);
			endcase
		end
	end

	// offer one value and hold it until accepted; valid stays high afterwards
	task send_value(logic [BIN_W-1:0] value);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_value(value);
	endtask

	task pause_sender(int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	// wait until every expected character has come out
	task wait_drained();
		pause_sender(1);
		while (sb.expected_text.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	// mix of full-range words, values of a chosen digit count, decade edges and small values
	function automatic logic [BIN_W-1:0] random_value();
		int unsigned lo;
		int unsigned hi;
		int unsigned mag;
		int          k;
		k  = $urandom_range(10, 1);
		lo = 1;
		repeat (k - 1) lo = lo * 10;
		hi = (k == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
		case ($urandom_range(3, 0))
			0: return $urandom;
			1: mag = $urandom_range(hi, lo);
			2: mag = $urandom_range(1, 0) ? lo : hi;
			default: mag = $urandom_range(99, 0);
		endcase
		return $urandom_range(1, 0) ? -mag : mag;
	endfunction

	// bursts of random length separated by random gaps
	task send_bursts(int count, int max_gap);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(12, 1);
			if (burst > count)
				burst = count;
			repeat (burst) send_value(random_value());
			count -= burst;
			pause_sender($urandom_range(max_gap, 0));
		end
	endtask

	logic [BIN_W-1:0] corner_values[$] = '{
		32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
		-32'sd999999999, -32'sd1000000000, 32'd1234567890, 32'h5555_5555,
		32'hAAAA_AAAA, 32'd5, -32'sd5, 32'd100000, 32'd1000000001
	};

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// corner values with an always-ready receiver
		rx_pattern = RX_ALWAYS;
		foreach (corner_values[i])
			send_value(corner_values[i]);
		wait_drained();

		// random values, receiver ready about half the time
		rx_pattern = RX_HALF;
		send_bursts(100, 6);

		// long receiver hold while the sender keeps pushing back to back
		hold_pending = 1'b1;
		repeat (40) send_value(random_value());
		pause_sender(0);
		send_bursts(20, 3);
		wait_drained();

		// sparse receiver, sender with long gaps
		rx_pattern = RX_SPARSE;
		send_bursts(80, 10);
		wait_drained();

		// full rate on both sides
		rx_pattern = RX_ALWAYS;
		send_bursts(60, 0);

		// mixed again to finish
		rx_pattern = RX_HALF;
		send_bursts(60, 4);
		wait_drained();

		foreach (sb.expected_text[i])
			sb.report_mismatch($sformatf("character %0d never came", sb.expected_text[i].ch));

		if (sb.errors == 0) begin
			$display("** signed_int_to_decimal_ascii_core: PASSED **");
		end else begin
			$display("** signed_int_to_decimal_ascii_core: FAILED **");
		end
		$finish;
	end

endmodule
